>>> src/btfc_pkg.sv
// ----------------------------------------------------------------------------
// btfc_pkg: shared types and codes for the balanced ternary fraction converter
// Item structs for both channels, balanced digit codes and parameter defaults.
// ----------------------------------------------------------------------------
package btfc_pkg;

	localparam int IN_BITS         = 63;
	localparam int DIGIT_SLOTS_DEF = 42;
	localparam int VALUE_BITS_DEF  = 64;

	// balanced ternary digit codes
	localparam logic [1:0] DIG_ZERO  = 2'd0;
	localparam logic [1:0] DIG_PLUS  = 2'd1;
	localparam logic [1:0] DIG_MINUS = 2'd2;

	typedef struct packed {
		logic [IN_BITS-1:0] numerator;
		logic [IN_BITS-1:0] denominator;
	} in_item_t;

	typedef struct packed {
		logic [1:0] digit;
		logic       point_after;
		logic       last;
	} out_item_t;

endpackage

>>> src/balanced_ternary_fraction_convert.sv
// ----------------------------------------------------------------------------
// balanced_ternary_fraction_convert: numerator / 3^k to balanced ternary
// Command in, one digit per strobe out, MSB first.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with operands; the transfer happens on an edge where busy is
//   low. Digits come out on result, one per cycle, each marked by strobe for
//   exactly one cycle; the receiver cannot stall, so it must take every one.
//   result.last flags the final digit of a number, result.point_after the
//   digit the radix point follows (none for an empty or all-zero fraction).
// Operation:
//   Front: one numerator bit a cycle through the ternary doubling register.
//   Back: a balanced sweep over the digit store, then one digit a cycle
//   for each emitted digit. Throughput is that of the slower of the two.
//   A two-entry job queue lets the front take a new command while the back
//   still emits the previous number.
// Reset:
//   arst_n clears both state machines and the queue; busy and strobe drop low.
// ----------------------------------------------------------------------------
module balanced_ternary_fraction_convert #(
	parameter int DIGIT_SLOTS = btfc_pkg::DIGIT_SLOTS_DEF,
	parameter int VALUE_BITS  = btfc_pkg::VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  btfc_pkg::in_item_t  operands,
	output logic                busy,
	output logic                strobe,
	output btfc_pkg::out_item_t result
);
	import btfc_pkg::*;

	localparam int TRITS = DIGIT_SLOTS - 1;
	localparam int IDX_W = $clog2(DIGIT_SLOTS);
	localparam int JOB_W = IDX_W + 2 * TRITS;

	// job = {fraction length, base-3 digits of the numerator}
	logic             push;
	logic [JOB_W-1:0] push_data;
	logic             full;
	logic             pop;
	logic [JOB_W-1:0] pop_data;
	logic             empty;

	btfc_front #(
		.DIGIT_SLOTS (DIGIT_SLOTS),
		.VALUE_BITS  (VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operands  (operands),
		.busy      (busy),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	btfc_queue #(
		.W (JOB_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// back drains the queue and emits; it never waits on the receiver
	btfc_back #(
		.DIGIT_SLOTS (DIGIT_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!empty),
		.job_data  (pop_data),
		.job_pop   (pop),
		.strobe    (strobe),
		.result    (result)
	);

endmodule

>>> src/btfc_front.sv
// ----------------------------------------------------------------------------
// btfc_front: command intake and base-3 conversion
// Shifts the numerator in MSB first, doubling a ternary register each bit,
// and counts the fraction length against a running power of three.
// ----------------------------------------------------------------------------
module btfc_front #(
	parameter  int DIGIT_SLOTS = btfc_pkg::DIGIT_SLOTS_DEF,
	parameter  int VALUE_BITS  = btfc_pkg::VALUE_BITS_DEF,
	localparam int TRITS       = DIGIT_SLOTS - 1,
	localparam int IDX_W       = $clog2(DIGIT_SLOTS),
	localparam int JOB_W       = IDX_W + 2 * TRITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  btfc_pkg::in_item_t  operands,
	output logic                busy,
	output logic                push,
	output logic [JOB_W-1:0]    push_data,
	input  logic                full
);
	import btfc_pkg::*;

	localparam int NUM_BITS = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
	localparam int CNT_W    = $clog2(NUM_BITS + 1);

	// ordinary base-3 digit values
	localparam logic [1:0] TRIT_0 = 2'd0;
	localparam logic [1:0] TRIT_1 = 2'd1;
	localparam logic [1:0] TRIT_2 = 2'd2;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CONV = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t              state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 den_run_q;
	logic [NUM_BITS-1:0]  num_q;
	logic [2*TRITS-1:0]   trits_q;
	logic [IN_BITS-1:0]   den_q;
	logic [IN_BITS:0]     pow_q;
	logic [IDX_W-1:0]     frac_q;

	logic [TRITS-1:0]     gen;
	logic [TRITS-1:0]     prop;
	logic [TRITS-1:0]     carry;
	logic [TRITS:0]       csum;
	logic [2*TRITS-1:0]   trits_nx;
	logic                 pow_le;
	logic [IN_BITS:0]     pow_x3;

	// x2 + bit: digit 2 always carries, digit 1 passes the incoming carry on,
	// so the carry chain is an ordinary add of (g|p) + g.
	always_comb begin
		for (int i = 0; i < TRITS; i++) begin
			gen[i]  = (trits_q[2*i +: 2] == TRIT_2);
			prop[i] = (trits_q[2*i +: 2] == TRIT_1);
		end
		csum  = {1'b0, gen | prop} + {1'b0, gen} + {{TRITS{1'b0}}, num_q[NUM_BITS-1]};
		carry = csum[TRITS-1:0] ^ (gen | prop) ^ gen;
		for (int i = 0; i < TRITS; i++) begin
			case (trits_q[2*i +: 2])
				TRIT_0:  trits_nx[2*i +: 2] = carry[i] ? TRIT_1 : TRIT_0;
				TRIT_1:  trits_nx[2*i +: 2] = carry[i] ? TRIT_0 : TRIT_2;
				TRIT_2:  trits_nx[2*i +: 2] = carry[i] ? TRIT_2 : TRIT_1;
				default: trits_nx[2*i +: 2] = TRIT_0;
			endcase
		end
	end

	assign pow_le = (pow_q <= {1'b0, den_q});
	assign pow_x3 = pow_q + {pow_q[IN_BITS-1:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			cnt_q     <= '0;
			den_run_q <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (start) begin
						state_q   <= F_CONV;
						cnt_q     <= CNT_W'(NUM_BITS);
						den_run_q <= 1'b1;
					end
				end
				F_CONV: begin
					if (cnt_q != '0)
						cnt_q <= cnt_q - 1'b1;
					if (den_run_q && !pow_le)
						den_run_q <= 1'b0;
					if (cnt_q == '0 && !den_run_q)
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && start) begin
			num_q   <= operands.numerator[NUM_BITS-1:0];
			den_q   <= operands.denominator;
			trits_q <= '0;
			pow_q   <= (IN_BITS+1)'(3);
			frac_q  <= '0;
		end else if (state_q == F_CONV) begin
			if (cnt_q != '0) begin
				num_q   <= num_q << 1;
				trits_q <= trits_nx;
			end
			if (den_run_q && pow_le) begin
				pow_q <= pow_x3;
				if (frac_q != IDX_W'(TRITS))
					frac_q <= frac_q + 1'b1;
			end
		end
	end

	assign busy      = (state_q != F_IDLE);
	assign push      = (state_q == F_PUSH) && !full;
	assign push_data = {frac_q, trits_q};

endmodule

>>> src/btfc_queue.sv
// ----------------------------------------------------------------------------
// btfc_queue: two-entry job queue
// Holds converted jobs between the front and the back.
// ----------------------------------------------------------------------------
module btfc_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);
	logic [W-1:0] slot_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_data;
	end

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = slot_q[rd_q];

endmodule

>>> src/btfc_back.sv
// ----------------------------------------------------------------------------
// btfc_back: balanced digit pass and digit emission
// Sweeps the base-3 digits LSB first into the digit store with carry,
// finds the trimmed span, then reads it out MSB first, one digit a cycle.
// ----------------------------------------------------------------------------
module btfc_back #(
	parameter  int DIGIT_SLOTS = btfc_pkg::DIGIT_SLOTS_DEF,
	localparam int TRITS       = DIGIT_SLOTS - 1,
	localparam int IDX_W       = $clog2(DIGIT_SLOTS),
	localparam int JOB_W       = IDX_W + 2 * TRITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  logic [JOB_W-1:0]    job_data,
	output logic                job_pop,
	output logic                strobe,
	output btfc_pkg::out_item_t result
);
	import btfc_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE  = 3'b001,
		B_SWEEP = 3'b010,
		B_EMIT  = 3'b100
	} bstate_t;

	bstate_t             state_q;
	logic [2*TRITS-1:0]  src_q;
	logic [IDX_W-1:0]    frac_q;
	logic [IDX_W-1:0]    k_q;
	logic                carry_q;
	logic [IDX_W-1:0]    zeros_q;
	logic                zrun_q;
	logic [IDX_W-1:0]    top_q;
	logic [1:0]          digit_store_q [DIGIT_SLOTS];

	logic                valid_s1;
	logic [1:0]          digit_s1;
	logic                point_s1;
	logic                last_s1;

	logic [2:0]          v;
	logic [1:0]          bal;
	logic                carry_nx;
	logic                top_hit;

	// digit plus carry: 2 becomes minus one with carry, 3 becomes zero with carry
	always_comb begin
		v = {1'b0, src_q[1:0]} + {2'b0, carry_q};
		case (v)
			3'd0: begin
				bal      = DIG_ZERO;
				carry_nx = 1'b0;
			end
			3'd1: begin
				bal      = DIG_PLUS;
				carry_nx = 1'b0;
			end
			3'd2: begin
				bal      = DIG_MINUS;
				carry_nx = 1'b1;
			end
			default: begin
				bal      = DIG_ZERO;
				carry_nx = 1'b1;
			end
		endcase
		top_hit = (k_q > frac_q) && (bal != DIG_ZERO);
	end

	assign job_pop = (state_q == B_IDLE) && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == B_EMIT);
			case (state_q)
				B_IDLE: begin
					if (job_valid)
						state_q <= B_SWEEP;
				end
				B_SWEEP: begin
					if (k_q == IDX_W'(DIGIT_SLOTS - 1))
						state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (k_q == zeros_q)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					src_q   <= job_data[2*TRITS-1:0];
					frac_q  <= job_data[JOB_W-1 -: IDX_W];
					top_q   <= job_data[JOB_W-1 -: IDX_W];
					k_q     <= '0;
					carry_q <= 1'b0;
					zeros_q <= '0;
					zrun_q  <= 1'b1;
				end
			end
			B_SWEEP: begin
				src_q   <= src_q >> 2;
				carry_q <= carry_nx;
				// trailing fraction zeros
				if (zrun_q && (k_q < frac_q) && (bal == DIG_ZERO))
					zeros_q <= zeros_q + 1'b1;
				else
					zrun_q <= 1'b0;
				// highest nonzero integer digit, units digit kept
				if (top_hit)
					top_q <= k_q;
				if (k_q == IDX_W'(DIGIT_SLOTS - 1))
					k_q <= top_hit ? k_q : top_q;
				else
					k_q <= k_q + 1'b1;
			end
			B_EMIT: begin
				point_s1 <= (k_q == frac_q) && (frac_q != '0) && (zeros_q != frac_q);
				last_s1  <= (k_q == zeros_q);
				k_q      <= k_q - 1'b1;
			end
			default: ;
		endcase
	end

	// digit store: one write port in the sweep, one registered read in emission
	always_ff @(posedge clk) begin
		if (state_q == B_SWEEP)
			digit_store_q[k_q] <= bal;
		digit_s1 <= digit_store_q[k_q];
	end

	assign strobe = valid_s1;

	always_comb begin
		result.digit       = digit_s1;
		result.point_after = point_s1;
		result.last        = last_s1;
	end

endmodule

>>> src/btfc_checker.sv
// ----------------------------------------------------------------------------
// btfc_checker: port-level checks for the balanced ternary converter
// Watches the command and digit channels, bound to the top level.
// ----------------------------------------------------------------------------
module btfc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                strobe,
	input btfc_pkg::out_item_t result
);
	import btfc_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	a_digit_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.digit == DIG_ZERO || result.digit == DIG_PLUS ||
			result.digit == DIG_MINUS))
		else $error("unused digit code on result");

	a_point_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.point_after |-> !result.last)
		else $error("radix point on final digit");

	a_digits_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("gap inside a number's digit run");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |=> !strobe)
		else $error("digit directly after final digit");

endmodule

bind balanced_ternary_fraction_convert btfc_checker u_btfc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.result (result)
);

>>> verif/balanced_ternary_fraction_convert_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// balanced_ternary_fraction_convert_test: self-checking bench for the converter
// Sends numerator / denominator commands through the start/busy handshake and
// checks every strobed digit against a local prediction of the balanced
// ternary expansion. The digit, the radix point flag and the end-of-number
// flag are all checked. Directed corner cases run first, then random traffic
// under several sender gap settings.
// ----------------------------------------------------------------------------
module balanced_ternary_fraction_convert_test;
	import btfc_pkg::*;

	localparam int SLOTS       = DIGIT_SLOTS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	// long enough for any stray trailing digit to show up after the drain
	localparam int SETTLE      = 300;

	logic        clk;
	logic        arst_n;
	logic        start;
	in_item_t    operands;
	logic        busy;
	logic        strobe;
	out_item_t   result;

	// digits still owed by the block, oldest first
	out_item_t   pending_digits[$];
	int          gap_pct;
	int          items_sent;
	int          digits_checked;
	int          points_seen;
	int          fail_count;
	int          cycle_count;

	balanced_ternary_fraction_convert dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operands (operands),
		.busy     (busy),
		.strobe   (strobe),
		.result   (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog: a stuck handshake or a lost digit ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("balanced_ternary_fraction_convert_test failed");
			$finish;
		end
	end

	function automatic logic [62:0] pow3(int k);
		logic [62:0] p;
		p = 63'd1;
		repeat (k) p = p * 3;
		return p;
	endfunction

	// Work out the balanced ternary digits of one command and queue them,
	// most significant first. Ordinary base-3 digits go into trit[], get
	// folded to balanced form by the carry pass (2 stays 2 meaning minus one
	// and carries, 3 becomes 0 and carries), then trimmed at both ends.
	function automatic void predict_digits(in_item_t it);
		logic [62:0] den;
		logic [63:0] work;
		int          trit[0:SLOTS-1];
		int          flen, n, m, k, top, zeros, carry, v;
		out_item_t   d;
		den  = it.denominator;
		flen = 0;
		while (den / 3 != 0) begin
			den = den / 3;
			if (flen < SLOTS - 1)
				flen++;
		end
		work = {1'b0, it.numerator};
		n    = 0;
		do begin
			if (n < SLOTS - 1) begin
				trit[n] = int'(work % 3);
				n++;
			end
			work = work / 3;
		end while (work != 0);
		m = (n > flen) ? n : flen;
		for (k = n; k < m; k++)
			trit[k] = 0;
		carry = 0;
		for (k = 0; k < m; k++) begin
			v = trit[k] + carry;
			if (v >= 2) begin
				trit[k] = (v == 2) ? 2 : 0;
				carry   = 1;
			end else begin
				trit[k] = v;
				carry   = 0;
			end
		end
		trit[m] = carry;
		// trailing fractional zeros go
		zeros = 0;
		while (zeros < flen && trit[zeros] == 0)
			zeros++;
		// leading integer zeros go, the units digit stays
		top = m;
		while (top > flen && trit[top] == 0)
			top--;
		for (k = top; k >= zeros; k--) begin
			case (trit[k])
				1:       d.digit = DIG_PLUS;
				2:       d.digit = DIG_MINUS;
				default: d.digit = DIG_ZERO;
			endcase
			d.point_after = (k == flen && flen != 0 && zeros != flen);
			d.last        = (k == zeros);
			pending_digits.push_back(d);
		end
	endfunction

	// One transfer: hold start and operands until an edge sees busy low,
	// then maybe leave the line idle for a few cycles.
	task automatic send_item(in_item_t it);
		start    <= 1'b1;
		operands <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_digits(it);
		items_sent++;
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Every strobed digit is matched against the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && strobe) begin
			if (pending_digits.size() == 0) begin
				$error("digit with nothing expected: digit %0d point_after %0b last %0b",
					result.digit, result.point_after, result.last);
				fail_count++;
			end else begin
				want = pending_digits.pop_front();
				digits_checked++;
				if (result.point_after)
					points_seen++;
				if (result.digit !== want.digit) begin
					$error("digit: expected %0d, got %0d", want.digit, result.digit);
					fail_count++;
				end
				if (result.point_after !== want.point_after) begin
					$error("point_after: expected %0b, got %0b",
						want.point_after, result.point_after);
					fail_count++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, result.last);
					fail_count++;
				end
			end
		end
	end

	// Numerators of random length; denominators mostly exact powers of three,
	// with off-power, wide random, zero and one mixed in.
	function automatic in_item_t random_operands();
		in_item_t    it;
		logic [63:0] raw;
		int          nbits, sel;
		raw   = {$urandom, $urandom};
		nbits = ($urandom_range(3) == 0) ? 63 : $urandom_range(63, 1);
		it.numerator = raw[62:0] & ((63'd1 << nbits) - 63'd1 | (nbits == 63 ? '1 : '0));
		sel = $urandom_range(9);
		if (sel <= 6)
			it.denominator = pow3($urandom_range(39, 0));
		else if (sel == 7)
			it.denominator = pow3($urandom_range(39, 1)) + 63'($urandom_range(5)) - 63'd1;
		else if (sel == 8) begin
			raw = {$urandom, $urandom};
			it.denominator = raw[62:0] >> $urandom_range(62, 0);
		end else
			it.denominator = 63'($urandom_range(1));
		return it;
	endfunction

	// Hold off the sender until every owed digit has come out.
	task automatic wait_for_drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_digits.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_pair(logic [62:0] num, logic [62:0] den);
		in_item_t it;
		it.numerator   = num;
		it.denominator = den;
		send_item(it);
	endtask

	// Corner values: zeros, ones, full-width fields, deepest fraction, all-two
	// and all-one ternary digits, off-power denominators, exact integers.
	task automatic test_directed();
		gap_pct = 0;
		send_pair(63'd0, 63'd1);
		send_pair(63'd0, 63'd0);                   // denominator zero
		send_pair(63'd1, 63'd1);
		send_pair(63'd2, 63'd1);                   // carry into a new top digit
		send_pair(63'd1, 63'd3);
		send_pair(63'd2, 63'd3);
		send_pair(63'd5, 63'd9);
		send_pair(63'd0, pow3(39));                // long fraction, all zero
		send_pair('1, 63'd1);
		send_pair('1, '1);
		send_pair('1, pow3(39));
		send_pair(63'd1, pow3(39));
		send_pair(pow3(39) - 63'd1, pow3(39));     // every ordinary digit a two
		send_pair((pow3(20) - 63'd1) / 2, pow3(20)); // every ordinary digit a one
		send_pair(63'h5555_5555_5555_5555, 63'd10);
		send_pair(63'h2aaa_aaaa_aaaa_aaaa, 63'd26);
		send_pair(63'd4, 63'd80);                  // just under a power of three
		send_pair(63'd13, 63'd2);
		send_pair(63'd8, 63'd27);
		send_pair(63'd9, 63'd27);                  // trailing fraction zeros
		send_pair(pow3(38), 63'd1);
		send_pair(pow3(39), pow3(39));             // exact integer, no point
	endtask

	task automatic test_random(int count, int pct);
		gap_pct = pct;
		repeat (count)
			send_item(random_operands());
	endtask

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		operands       = '0;
		gap_pct        = 0;
		items_sent     = 0;
		digits_checked = 0;
		points_seen    = 0;
		fail_count     = 0;
		cycle_count    = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(85, 0);    // back to back
		wait_for_drain();      // sender waits for a quiet block once
		test_random(85, 88);   // sparse commands
		test_random(85, 20);   // light gaps

		start <= 1'b0;
		@(posedge clk);
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d numbers, %0d digits checked, %0d radix points",
			items_sent, digits_checked, points_seen);
		$display("gap settings: none, 88 of 100 cycles, 20 of 100, plus one full drain");
		if (fail_count == 0)
			$display("balanced_ternary_fraction_convert_test passed");
		else
			$display("balanced_ternary_fraction_convert_test failed");
		$finish;
	end

endmodule
